// ===== rtl/brightness_boost_envelope_macros.svh =====
// ----------------------------------------------------------------------------
// Brightness boost envelope assertion macros
// Shared concurrent assertion forms for the envelope RTL.
// ----------------------------------------------------------------------------
`ifndef BRIGHTNESS_BOOST_ENVELOPE_MACROS_SVH
`define BRIGHTNESS_BOOST_ENVELOPE_MACROS_SVH

`ifndef SYNTHESIS

// Consequent must hold in the same cycle as the antecedent.
`define BBE_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("envelope assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define BBE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("envelope assertion failed");

`else

`define BBE_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define BBE_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/bbe_pkg.sv =====
// ----------------------------------------------------------------------------
// Brightness boost envelope package
// Widths, reset values, register indexes and payload types of the envelope.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bbe_pkg;

    // Field widths.
    localparam int FACTOR_W = 16;   // unsigned Q8.8
    localparam int TIME_W   = 24;   // unsigned Q8.16 seconds
    localparam int DELTA_W  = 16;   // tick length, Q8.16 below one second
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    // Slew rates in factor units per second.
    localparam int RISE_RATE = 150;
    localparam int FALL_RATE = 15;

    // Register reset values.
    localparam logic [FACTOR_W-1:0] DEFAULT_FACTOR_RST = 16'd205;
    localparam logic [FACTOR_W-1:0] PEAK_FACTOR_RST    = 16'd1280;
    localparam logic [TIME_W-1:0]   BOOST_LENGTH_RST   = 24'd327680;
    localparam logic [TIME_W-1:0]   PEAK_LENGTH_RST    = 24'd6554;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_FACTOR = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PEAK_FACTOR    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BOOST_LENGTH   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PEAK_LENGTH    = 3'd3;

    // Input item actions.
    localparam logic ACT_TICK  = 1'b0;
    localparam logic ACT_START = 1'b1;

    typedef struct packed {
        logic                action;
        logic [DELTA_W-1:0]  delta_time;
    } t_in_item;

    typedef struct packed {
        logic [FACTOR_W-1:0] gain_factor;
        logic                boost_active;
    } t_out_item;

    typedef struct packed {
        logic [FACTOR_W-1:0] default_factor;
        logic [FACTOR_W-1:0] peak_factor;
        logic [TIME_W-1:0]   boost_length;
        logic [TIME_W-1:0]   peak_length;
    } t_cfg;

endpackage

// ===== rtl/bbe_step.sv =====
// ----------------------------------------------------------------------------
// Brightness boost envelope update step
// Next countdown and gain factor for one item, computed in one pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bbe_step (
    input  bbe_pkg::t_cfg                     i_cfg,
    input  bbe_pkg::t_in_item                 i_item,
    input  logic [bbe_pkg::TIME_W-1:0]        i_countdown,
    input  logic [bbe_pkg::FACTOR_W-1:0]      i_factor,
    output logic [bbe_pkg::TIME_W-1:0]        o_countdown,
    output logic [bbe_pkg::FACTOR_W-1:0]      o_factor
);
    import bbe_pkg::*;

    logic [TIME_W-1:0]   dt_ext;
    logic [TIME_W-1:0]   cd_sub;
    logic [TIME_W-1:0]   elapsed;
    logic                in_peak;
    logic [23:0]         rise_prod;
    logic [19:0]         fall_prod;
    logic [FACTOR_W-1:0] step;
    logic [FACTOR_W-1:0] target;
    logic [FACTOR_W:0]   up_sum;
    logic [FACTOR_W:0]   lim_sum;
    logic [FACTOR_W-1:0] slewed;

    assign dt_ext = TIME_W'(i_item.delta_time);
    assign cd_sub = i_countdown - dt_ext;

    // Elapsed boost time saturates at zero when the countdown exceeds the length.
    assign elapsed = (i_cfg.boost_length > cd_sub) ? (i_cfg.boost_length - cd_sub) : '0;
    assign in_peak = (elapsed < i_cfg.peak_length);

    // Slew steps: floor(rate * dt / 256) in Q8.8 units.
    assign rise_prod = 24'(i_item.delta_time) * 24'(RISE_RATE);
    assign fall_prod = 20'(i_item.delta_time) * 20'(FALL_RATE);

    assign step   = in_peak ? rise_prod[23:8] : {4'b0, fall_prod[19:8]};
    assign target = in_peak ? i_cfg.peak_factor : i_cfg.default_factor;

    // Move the factor toward the target by one step, stopping at the target.
    assign up_sum  = {1'b0, i_factor} + {1'b0, step};
    assign lim_sum = {1'b0, target} + {1'b0, step};

    always_comb begin
        if (i_factor < target) begin
            slewed = (up_sum > {1'b0, target}) ? target : up_sum[FACTOR_W-1:0];
        end else if (i_factor > target) begin
            slewed = ({1'b0, i_factor} < lim_sum) ? target : (i_factor - step);
        end else begin
            slewed = i_factor;
        end
    end

    // Start reloads, an ending tick restores the default, a running tick slews, and an idle tick holds.
    always_comb begin
        o_countdown = i_countdown;
        o_factor    = i_factor;
        if (i_item.action == ACT_START) begin
            o_countdown = i_cfg.boost_length;
        end else if (i_countdown != '0) begin
            if (dt_ext >= i_countdown) begin
                o_countdown = '0;
                o_factor    = i_cfg.default_factor;
            end else begin
                o_countdown = cd_sub;
                o_factor    = slewed;
            end
        end
    end

endmodule

// ===== rtl/brightness_boost_envelope.sv =====
// An item passes through the input register and then the update and result
// register before its result is offered. Throughput: one item per cycle while
// the result port is not stalled; the state update is a single pass.
// Reset (i_rst_n low, synchronous) empties both registers, loads the register
// reset values, clears the countdown and sets the gain to the default factor.
// ----------------------------------------------------------------------------
// Brightness boost envelope
// Timed boost envelope for a display gain factor with a configuration port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "brightness_boost_envelope_macros.svh"

module brightness_boost_envelope (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // Input items.
    input  logic                               i_in_valid,
    input  bbe_pkg::t_in_item                  i_in_item,
    output logic                               o_in_stall,
    // Result items.
    output logic                               o_out_valid,
    output bbe_pkg::t_out_item                 o_out_item,
    input  logic                               i_out_stall,
    // Configuration writes.
    input  logic                               i_cfg_valid,
    input  logic [bbe_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [bbe_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    output logic                               o_cfg_ready
);
    import bbe_pkg::*;

    t_cfg                r_cfg;
    t_cfg                n_cfg;
    logic [TIME_W-1:0]   r_countdown;
    logic [TIME_W-1:0]   n_countdown;
    logic [FACTOR_W-1:0] r_factor_now;
    logic [FACTOR_W-1:0] n_factor_now;
    logic                r_in_valid;
    t_in_item            r_in_item;
    logic                r_out_valid;
    t_out_item           r_out_item;

    logic [TIME_W-1:0]   step_countdown;
    logic [FACTOR_W-1:0] step_factor;
    logic                out_free;
    logic                s1_move;
    logic                cfg_we;

    // Handshake: the result register frees when empty or taken.
    assign out_free   = !r_out_valid || !i_out_stall;
    assign s1_move    = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;
    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;

    // Update logic for the item in the input register.
    bbe_step u_step (
        .i_cfg       (r_cfg),
        .i_item      (r_in_item),
        .i_countdown (r_countdown),
        .i_factor    (r_factor_now),
        .o_countdown (step_countdown),
        .o_factor    (step_factor)
    );

    // Register writes; a default written while idle also sets the gain.
    always_comb begin
        n_cfg        = r_cfg;
        n_countdown  = r_countdown;
        n_factor_now = r_factor_now;
        if (cfg_we) begin
            unique case (i_cfg_index)
                CFG_DEFAULT_FACTOR: begin
                    n_cfg.default_factor = i_cfg_data[FACTOR_W-1:0];
                    if (r_countdown == '0) begin
                        n_factor_now = i_cfg_data[FACTOR_W-1:0];
                    end
                end
                CFG_PEAK_FACTOR:  n_cfg.peak_factor  = i_cfg_data[FACTOR_W-1:0];
                CFG_BOOST_LENGTH: n_cfg.boost_length = i_cfg_data[TIME_W-1:0];
                CFG_PEAK_LENGTH:  n_cfg.peak_length  = i_cfg_data[TIME_W-1:0];
                default: begin
                end
            endcase
        end
        if (s1_move) begin
            n_countdown  = step_countdown;
            n_factor_now = step_factor;
        end
    end

    // Control and state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.default_factor <= DEFAULT_FACTOR_RST;
            r_cfg.peak_factor    <= PEAK_FACTOR_RST;
            r_cfg.boost_length   <= BOOST_LENGTH_RST;
            r_cfg.peak_length    <= PEAK_LENGTH_RST;
            r_countdown          <= '0;
            r_factor_now         <= DEFAULT_FACTOR_RST;
            r_in_valid           <= 1'b0;
            r_out_valid          <= 1'b0;
        end else begin
            r_cfg        <= n_cfg;
            r_countdown  <= n_countdown;
            r_factor_now <= n_factor_now;
            if (!o_in_stall) begin
                r_in_valid <= i_in_valid;
            end
            if (s1_move) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (!o_in_stall) begin
            r_in_item <= i_in_item;
        end
        if (s1_move) begin
            r_out_item.gain_factor  <= step_factor;
            r_out_item.boost_active <= (step_countdown != '0);
        end
    end

    // The result register shows the state that its item left.
    `BBE_ASSERT_NEXT(a_out_gain, i_clk, i_rst_n, s1_move, r_out_item.gain_factor == r_factor_now)
    `BBE_ASSERT_NEXT(a_out_active, i_clk, i_rst_n, s1_move, r_out_item.boost_active == (r_countdown != '0))
    // A tick never raises the countdown.
    `BBE_ASSERT_NEXT(a_tick_down, i_clk, i_rst_n, s1_move && (r_in_item.action == ACT_TICK), r_countdown <= $past(r_countdown))
    // Stall is only raised with a held item that cannot move on.
    `BBE_ASSERT_SAME(a_stall_held, i_clk, i_rst_n, o_in_stall, r_in_valid && r_out_valid)

endmodule
